// ===== rtl/three_level_frame_priority_queue_core_assert.svh =====
`ifndef THREE_LEVEL_FRAME_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define THREE_LEVEL_FRAME_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, checked on clk_i outside of reset
`define TLFPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk_i outside of reset
`define TLFPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tlfpq_pkg.sv =====
package tlfpq_pkg;

  localparam int unsigned NUM_QUEUES  = 3;
  localparam int unsigned HANDLE_BITS = 8;
  localparam int unsigned LEN_BITS    = 24;
  localparam int unsigned BYTES_BITS  = 25;

  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_HEAD = 2'd2;

  localparam logic [1:0] PRIO_HIGH = 2'd0;
  localparam logic [1:0] PRIO_MED  = 2'd1;
  localparam logic [1:0] PRIO_LOW  = 2'd2;
  localparam logic [1:0] LOCK_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                   req_type;
    logic [1:0]             priority_req;
    logic [HANDLE_BITS-1:0] frame_handle;
    logic [LEN_BITS-1:0]    payload_length;
    logic [BYTES_BITS-1:0]  bytes_written;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   frame_finished;
    logic                   next_valid;
    logic [1:0]             next_priority;
    logic [HANDLE_BITS-1:0] next_handle;
    logic [BYTES_BITS-1:0]  next_offset;
    logic [BYTES_BITS-1:0]  next_remaining;
    logic                   data_pending;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [LEN_BITS-1:0]    len;
  } entry_t;

endpackage

// ===== rtl/three_level_frame_priority_queue_core.sv =====
// the result is registered in ST_RESP and marked by done_o; a report that completes a frame while its
// queue still holds another first passes through ST_FILL (next head read from frame ram)
// busy is high from acceptance until the result is registered, and no new request is taken meanwhile
// the receiver cannot stall: done_o marks each result for exactly one cycle
// reset: queues empty, no write lock, no result pending; the frame ram is not cleared
`include "three_level_frame_priority_queue_core_assert.svh"

module three_level_frame_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned HEADER_BYTES = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tlfpq_pkg::req_t  req_i,
  output logic             done_o,
  output tlfpq_pkg::rsp_t  rsp_o
);

  localparam int unsigned NQ        = tlfpq_pkg::NUM_QUEUES;
  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NQ * QUEUE_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned SIZE_W    = tlfpq_pkg::BYTES_BITS;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]    PTR_WRAP = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);

  tlfpq_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0]  head_ptr_q [NQ];
  logic [CNT_W-1:0]  cnt_q      [NQ];
  logic [SIZE_W-1:0] written_q  [NQ];
  tlfpq_pkg::entry_t head_q     [NQ];
  logic [1:0]        lock_q;
  logic [1:0]        status_q;
  logic              finished_q;
  logic [1:0]        fill_q;
  logic              done_q;
  tlfpq_pkg::rsp_t   rsp_q, rsp_d;

  tlfpq_pkg::entry_t mem [MEM_DEPTH];
  tlfpq_pkg::entry_t rd_data_q;

  logic              accept;
  logic              is_submit;
  logic [NQ-1:0]     pri_oh;
  logic [CNT_W-1:0]  cnt_pri;
  logic [PTR_W-1:0]  head_pri;
  logic [ADDR_W-1:0] base_pri;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic              sub_ok;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  tlfpq_pkg::entry_t wr_data;

  logic [NQ-1:0]     hit_oh;
  logic              hit_found;
  logic [1:0]        hit_idx;
  tlfpq_pkg::entry_t hit_entry;
  logic [SIZE_W-1:0] hit_written;
  logic [CNT_W-1:0]  hit_cnt;
  logic [PTR_W-1:0]  hit_head;
  logic [ADDR_W-1:0] hit_base;
  logic [SIZE_W:0]   wr_sum;
  logic [SIZE_W-1:0] hit_size;
  logic              complete;
  logic [PTR_W-1:0]  pop_head;
  logic [CNT_W-1:0]  pop_cnt;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [NQ-1:0]     sel_oh;
  logic              sel_found;
  logic [1:0]        sel_idx;
  tlfpq_pkg::entry_t sel_entry;
  logic [SIZE_W-1:0] sel_written;
  logic [SIZE_W-1:0] sel_size;
  logic              pending;

  assign busy      = (state_q != tlfpq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_submit = (req_i.req_type == tlfpq_pkg::REQ_SUBMIT);

  // submit path: tail slot of the requested queue
  always_comb begin
    pri_oh   = '0;
    cnt_pri  = '0;
    head_pri = '0;
    base_pri = '0;
    for (int q = 0; q < NQ; q++) begin
      pri_oh[q] = (req_i.priority_req == 2'(q));
      if (pri_oh[q]) begin
        cnt_pri  = cnt_q[q];
        head_pri = head_ptr_q[q];
        base_pri = ADDR_W'(q * QUEUE_DEPTH);
      end
    end
    sub_ok   = (pri_oh != '0) && (cnt_pri != CNT_FULL);
    // count is below depth here, so the low bits hold it whole
    tail_sum = {1'b0, head_pri} + {1'b0, cnt_pri[PTR_W-1:0]};
    tail     = (tail_sum >= PTR_WRAP) ? PTR_W'(tail_sum - PTR_WRAP) : tail_sum[PTR_W-1:0];
    wr_en    = accept && is_submit && sub_ok;
    wr_addr  = base_pri + ADDR_W'(tail);
    wr_data.handle = req_i.frame_handle;
    wr_data.len    = req_i.payload_length;
  end

  // report path: highest-priority head that matches the handle
  always_comb begin
    hit_oh      = '0;
    hit_found   = 1'b0;
    hit_idx     = tlfpq_pkg::LOCK_NONE;
    hit_entry   = '0;
    hit_written = '0;
    hit_cnt     = '0;
    hit_head    = '0;
    hit_base    = '0;
    for (int q = 0; q < NQ; q++) begin
      if (!hit_found && cnt_q[q] != '0 && head_q[q].handle == req_i.frame_handle) begin
        hit_oh[q]   = 1'b1;
        hit_found   = 1'b1;
        hit_idx     = 2'(q);
        hit_entry   = head_q[q];
        hit_written = written_q[q];
        hit_cnt     = cnt_q[q];
        hit_head    = head_ptr_q[q];
        hit_base    = ADDR_W'(q * QUEUE_DEPTH);
      end
    end
    wr_sum   = {1'b0, hit_written} + {1'b0, req_i.bytes_written};
    hit_size = {1'b0, hit_entry.len} + HDR;
    complete = (wr_sum >= {1'b0, hit_size});
    pop_head = (hit_head == PTR_LAST) ? '0 : hit_head + PTR_W'(1);
    pop_cnt  = hit_cnt - CNT_W'(1);
    rd_en    = accept && !is_submit && hit_found && complete && (pop_cnt != '0);
    rd_addr  = hit_base + ADDR_W'(pop_head);
  end

  // frame ram: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlfpq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlfpq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rd_en ? tlfpq_pkg::ST_FILL : tlfpq_pkg::ST_RESP;
        end
      end
      tlfpq_pkg::ST_FILL: begin
        state_d = tlfpq_pkg::ST_RESP;
      end
      tlfpq_pkg::ST_RESP: begin
        state_d = tlfpq_pkg::ST_IDLE;
      end
      default: begin
        state_d = tlfpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NQ; q++) begin
        head_ptr_q[q] <= '0;
        cnt_q[q]      <= '0;
        written_q[q]  <= '0;
      end
      lock_q     <= tlfpq_pkg::LOCK_NONE;
      status_q   <= tlfpq_pkg::STATUS_OK;
      finished_q <= 1'b0;
      fill_q     <= tlfpq_pkg::PRIO_HIGH;
      done_q     <= 1'b0;
    end else begin
      done_q <= (state_q == tlfpq_pkg::ST_RESP);
      if (accept) begin
        if (is_submit) begin
          status_q   <= sub_ok ? tlfpq_pkg::STATUS_OK : tlfpq_pkg::STATUS_FULL;
          finished_q <= 1'b0;
          for (int q = 0; q < NQ; q++) begin
            if (sub_ok && pri_oh[q]) begin
              cnt_q[q] <= cnt_q[q] + CNT_W'(1);
            end
          end
        end else if (!hit_found) begin
          status_q   <= tlfpq_pkg::STATUS_NO_HEAD;
          finished_q <= 1'b0;
        end else begin
          status_q   <= tlfpq_pkg::STATUS_OK;
          fill_q     <= hit_idx;
          finished_q <= complete;
          if (complete) begin
            lock_q <= tlfpq_pkg::LOCK_NONE;
          end else begin
            lock_q <= hit_idx;
          end
          for (int q = 0; q < NQ; q++) begin
            if (hit_oh[q]) begin
              if (complete) begin
                written_q[q]  <= '0;
                head_ptr_q[q] <= pop_head;
                cnt_q[q]      <= pop_cnt;
              end else begin
                written_q[q] <= wr_sum[SIZE_W-1:0];
              end
            end
          end
        end
      end
    end
  end

  // head cache: loaded on submit into an empty queue or from ram after a pop
  always_ff @(posedge clk_i) begin
    for (int q = 0; q < NQ; q++) begin
      if (wr_en && pri_oh[q] && cnt_q[q] == '0) begin
        head_q[q] <= wr_data;
      end else if (state_q == tlfpq_pkg::ST_FILL && fill_q == 2'(q)) begin
        head_q[q] <= rd_data_q;
      end
    end
  end

  // result: locked queue head, else highest non-empty queue
  always_comb begin
    sel_oh      = '0;
    sel_found   = 1'b0;
    sel_idx     = tlfpq_pkg::PRIO_HIGH;
    sel_entry   = '0;
    sel_written = '0;
    pending     = 1'b0;
    for (int q = 0; q < NQ; q++) begin
      pending = pending || (cnt_q[q] != '0);
      if (lock_q != tlfpq_pkg::LOCK_NONE) begin
        sel_oh[q] = (lock_q == 2'(q)) && (cnt_q[q] != '0);
      end else begin
        sel_oh[q] = !sel_found && (cnt_q[q] != '0);
      end
      if (sel_oh[q]) begin
        sel_found   = 1'b1;
        sel_idx     = 2'(q);
        sel_entry   = head_q[q];
        sel_written = written_q[q];
      end
    end
    sel_size = {1'b0, sel_entry.len} + HDR;

    rsp_d.status         = status_q;
    rsp_d.frame_finished = finished_q;
    rsp_d.next_valid     = sel_found;
    rsp_d.next_priority  = sel_found ? sel_idx : tlfpq_pkg::PRIO_HIGH;
    rsp_d.next_handle    = sel_found ? sel_entry.handle : '0;
    rsp_d.next_offset    = sel_found ? sel_written : '0;
    rsp_d.next_remaining = (sel_found && sel_size > sel_written) ? sel_size - sel_written : '0;
    rsp_d.data_pending   = pending;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tlfpq_pkg::ST_RESP) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `TLFPQ_ASSERT_NEXT(a_resp_strobes, state_q == tlfpq_pkg::ST_RESP, done_o, "result strobe missing after response cycle")
  `TLFPQ_ASSERT_NEXT(a_strobe_single, done_o, !done_o, "result strobe held longer than one cycle")
  `TLFPQ_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_q[0] <= CNT_FULL) && (cnt_q[1] <= CNT_FULL) && (cnt_q[2] <= CNT_FULL), "queue count beyond depth")
  `TLFPQ_ASSERT_NOW(a_lock_nonempty, lock_q != tlfpq_pkg::LOCK_NONE, (lock_q == tlfpq_pkg::PRIO_HIGH && cnt_q[0] != '0) || (lock_q == tlfpq_pkg::PRIO_MED && cnt_q[1] != '0) || (lock_q == tlfpq_pkg::PRIO_LOW && cnt_q[2] != '0), "write lock on an empty queue")
  `TLFPQ_ASSERT_NOW(a_valid_pending, done_o && rsp_o.next_valid, rsp_o.data_pending, "next frame named with no data pending")

endmodule
